FILE: src/lrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the ranged LCG random block.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int STATE_W = 31;
  localparam int CNT_W   = 5;

  localparam logic [STATE_W-1:0] LCG_MUL    = 31'd1103515245;
  localparam logic [STATE_W-1:0] LCG_ADD    = 31'd12345;
  localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;
  localparam logic [6:0]         PCT_DIV    = 7'd100;

  localparam logic [CNT_W-1:0]   DIV_LAST   = CNT_W'(STATE_W - 1);

  typedef enum logic [1:0] {
    MODE_UNSIGNED = 2'd0,
    MODE_SIGNED   = 2'd1,
    MODE_PERCENT  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_SEED = 1'b0
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

FILE: src/lcg_ranged_random.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_ranged_random
// 31-bit LCG with ranged, signed-ranged and percent-test outputs.
// Each request runs one state step, then 31 restoring divide iterations on
//   one shared subtract/compare, then a finish step.
// A new request is not accepted until the previous result has left ST_FINISH.
// Reset: synchronous; seed_start and the generator state load 1.
// ----------------------------------------------------------------------------
module lcg_ranged_random
  import lrr_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [VALUE_WIDTH-1:0] bound_low,
  input  logic [VALUE_WIDTH-1:0] bound_high,
  input  logic [6:0]             percent,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   hit,
  output logic                   span_zero,
  output logic [STATE_W-1:0]     raw_state,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = VALUE_WIDTH + 32;
  localparam bit WORD64 = (VALUE_WIDTH >= 64);

  state_t state, state_next;

  logic [STATE_W-1:0]     seed_start;
  logic [STATE_W-1:0]     gen_state;
  mode_t                  mode_q;
  logic [VALUE_WIDTH-1:0] low_q;
  logic [VALUE_WIDTH-1:0] high_q;
  logic [6:0]             pct_q;
  logic [VALUE_WIDTH-1:0] divisor;
  logic                   bypass;
  logic                   zero_q;
  logic [STATE_W-1:0]     rem;
  logic [STATE_W-1:0]     dividend;
  logic [CNT_W-1:0]       cnt;

  logic                   cfg_wr;
  logic                   in_accept;
  logic                   out_load;
  logic [2*STATE_W-1:0]   product;
  logic [STATE_W-1:0]     state_step;
  logic [VALUE_WIDTH-1:0] diff_u;
  logic [VALUE_WIDTH:0]   diff_s;
  logic [VALUE_WIDTH-1:0] divisor_next;
  logic                   bypass_next;
  logic                   zero_next;
  logic [STATE_W:0]       shifted;
  logic                   fits;
  logic [CW-1:0]          sub_res;
  logic [STATE_W-1:0]     rem_sel;
  logic [VALUE_WIDTH-1:0] range_sum;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_SEED: prdata = {1'b0, seed_start};
      default:  prdata = 32'd0;
    endcase
  end

  // state step: multiply, add, wrap to 31 bits
  assign product    = {{STATE_W{1'b0}}, gen_state} * {{STATE_W{1'b0}}, LCG_MUL};
  assign state_step = product[STATE_W-1:0] + LCG_ADD;

  // divisor setup
  assign diff_u = high_q - low_q;
  assign diff_s = {high_q[VALUE_WIDTH-1], high_q} - {low_q[VALUE_WIDTH-1], low_q};

  always_comb begin
    divisor_next = VALUE_WIDTH'(PCT_DIV);
    bypass_next  = 1'b0;
    zero_next    = 1'b0;
    unique case (mode_q)
      MODE_UNSIGNED: begin
        divisor_next = diff_u;
        zero_next    = (diff_u == '0);
      end
      MODE_SIGNED: begin
        divisor_next = diff_s[VALUE_WIDTH-1:0];
        bypass_next  = !WORD64 && diff_s[VALUE_WIDTH];
        zero_next    = (diff_s[VALUE_WIDTH-1:0] == '0) && (WORD64 || !diff_s[VALUE_WIDTH]);
      end
      default: begin
        divisor_next = VALUE_WIDTH'(PCT_DIV);
      end
    endcase
  end

  // shared restoring divide step
  assign shifted = {rem, dividend[STATE_W-1]};
  assign sub_res = CW'(shifted) - CW'(divisor);
  assign fits    = (CW'(shifted) >= CW'(divisor));

  assign rem_sel   = bypass ? gen_state : rem;
  assign range_sum = low_q + VALUE_WIDTH'(rem_sel);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_accept) state_next = ST_STEP;
      ST_STEP:   state_next = ST_DIV;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_start <= SEED_RESET;
      gen_state  <= SEED_RESET;
    end else if (cfg_wr && (reg_index_t'(paddr[2]) == REG_SEED)) begin
      seed_start <= pwdata[STATE_W-1:0];
      gen_state  <= pwdata[STATE_W-1:0];
    end else if (state == ST_STEP) begin
      gen_state <= state_step;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= mode_t'(mode);
      low_q  <= bound_low;
      high_q <= bound_high;
      pct_q  <= percent;
    end
    if (state == ST_STEP) begin
      divisor  <= divisor_next;
      bypass   <= bypass_next;
      zero_q   <= zero_next;
      rem      <= '0;
      dividend <= state_step;
      cnt      <= '0;
    end else if (state == ST_DIV) begin
      rem      <= fits ? sub_res[STATE_W-1:0] : shifted[STATE_W-1:0];
      dividend <= {dividend[STATE_W-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      raw_state <= gen_state;
      value     <= '0;
      hit       <= 1'b0;
      span_zero <= 1'b0;
      unique case (mode_q) inside
        MODE_UNSIGNED, MODE_SIGNED: begin
          span_zero <= zero_q;
          value     <= zero_q ? low_q : range_sum;
        end
        MODE_PERCENT: begin
          hit <= (rem[6:0] < pct_q);
        end
        default: begin
          value <= '0;
        end
      endcase
    end
  end

endmodule
